### hdl/s2i_pkg.sv
// shared types and constants for the string to integer converter
package s2i_pkg;

    localparam int SYM_W     = 8;
    localparam int SYM_MAX   = 16;
    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;
    localparam int BASE_W    = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYM_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYM_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd2;

    // reset alphabet "0123456789"
    localparam logic [CFG_DAT_W-1:0] SYM_LO_RST = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DAT_W-1:0] SYM_HI_RST = 64'h0000_0000_0000_3938;
    localparam logic [BASE_W-1:0]    BASE_RST   = 5'd10;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;

    // alphabet as seen by the converter
    typedef struct packed {
        logic [2*CFG_DAT_W-1:0] symbols;
        logic [BASE_W-1:0]      base_len;
        logic                   ok;
    } t_alpha;

endpackage

### hdl/s2i_if.sv
// channel interfaces: character stream, result stream, configuration writes
interface s2i_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface s2i_value_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2i_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/s2i_cfg.sv
// configuration registers and alphabet check
module s2i_cfg #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [s2i_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [s2i_pkg::CFG_DAT_W-1:0]     i_data,
    output s2i_pkg::t_alpha                   o_alpha
);
    import s2i_pkg::*;

    logic [CFG_DAT_W-1:0] r_sym_lo;
    logic [CFG_DAT_W-1:0] r_sym_hi;
    logic [BASE_W-1:0]    r_base;
    logic                 n_ok;
    logic [2*CFG_DAT_W-1:0] w_syms;

    assign w_syms = {r_sym_hi, r_sym_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lo <= SYM_LO_RST;
            r_sym_hi <= SYM_HI_RST;
            r_base   <= BASE_RST;
        end else begin
            if (i_wr) begin
                case (i_idx)
                    REG_SYM_LO: r_sym_lo <= i_data;
                    REG_SYM_HI: r_sym_hi <= i_data;
                    REG_BASE:   r_base   <= i_data[BASE_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // every pair compare is independent, so the nested loops stay shallow
    always_comb begin
        logic [SYM_W-1:0] s;
        n_ok = (r_base >= BASE_MIN) && (r_base <= BASE_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            s = w_syms[SYM_W*i +: SYM_W];
            if (BASE_W'(i) < r_base) begin
                if (s <= CH_SPACE || s >= CH_DEL || s == CH_PLUS || s == CH_MINUS)
                    n_ok = 1'b0;
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (BASE_W'(j) < r_base && w_syms[SYM_W*j +: SYM_W] == s)
                        n_ok = 1'b0;
                end
            end
        end
    end

    assign o_alpha.symbols  = w_syms;
    assign o_alpha.base_len = r_base;
    assign o_alpha.ok       = n_ok;

endmodule

### hdl/s2i_conv.sv
// input register, parse state update and result register
module s2i_conv #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s2i_pkg::t_alpha               i_alpha,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [s2i_pkg::CHAR_W-1:0]    i_char,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [s2i_pkg::VALUE_W-1:0]   o_value
);
    import s2i_pkg::*;

    localparam int DIGIT_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int PROD_W  = VALUE_W + BASE_W;

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_DIGS = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    logic               r_in_vld;
    logic [CHAR_W-1:0]  r_char;
    logic [1:0]         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic               r_out_vld;
    logic [VALUE_W-1:0] r_value, n_value;

    logic               w_adv;
    logic               w_term;
    logic               w_hit;
    logic [DIGIT_W-1:0] w_digit;
    logic [PROD_W-1:0]  w_prod;

    assign w_term     = (r_char == CH_NUL);
    assign w_adv      = r_in_vld && (!w_term || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    // lowest matching symbol index wins
    always_comb begin
        w_hit   = 1'b0;
        w_digit = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (BASE_W'(i) < i_alpha.base_len &&
                i_alpha.symbols[SYM_W*i +: SYM_W] == r_char) begin
                w_hit   = 1'b1;
                w_digit = DIGIT_W'(i);
            end
        end
        if (i_alpha.base_len > BASE_W'(MAX_SYMBOLS))
            w_hit = 1'b0;
    end

    assign w_prod = PROD_W'(r_mag) * PROD_W'(i_alpha.base_len) + PROD_W'(w_digit);

    always_comb begin
        logic       digs;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        digs    = (r_phase == PH_DIGS);
        if (r_phase == PH_SKIP) begin
            if (r_char == CH_SPACE || (r_char >= CH_TAB && r_char <= CH_CR)) begin
                digs = 1'b0;
            end else if (r_char == CH_MINUS || r_char == CH_PLUS) begin
                n_neg   = (r_char == CH_MINUS);
                n_phase = PH_DIGS;
                digs    = 1'b0;
            end else begin
                n_phase = PH_DIGS;
                digs    = 1'b1;
            end
        end
        if (digs) begin
            if (!w_hit)
                n_phase = PH_STOP;
            else if (w_prod > PROD_W'(MAG_LIMIT))
                n_mag = MAG_LIMIT;
            else
                n_mag = w_prod[VALUE_W-1:0];
        end
    end

    // magnitude never exceeds 2^31, so its top bit marks saturation
    always_comb begin
        if (!i_alpha.ok)
            n_value = '0;
        else if (r_neg)
            n_value = '0 - r_mag;
        else if (r_mag[VALUE_W-1])
            n_value = POS_MAX;
        else
            n_value = r_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= PH_SKIP;
            r_neg     <= 1'b0;
            r_mag     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready)
                r_in_vld <= i_in_valid;
            if (w_adv && w_term)
                r_out_vld <= 1'b1;
            else if (i_out_ready)
                r_out_vld <= 1'b0;
            if (w_adv) begin
                if (w_term) begin
                    r_phase <= PH_SKIP;
                    r_neg   <= 1'b0;
                    r_mag   <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_mag   <= n_mag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid)
            r_char <= i_char;
        if (w_adv && w_term)
            r_value <= n_value;
    end

    assign o_out_valid = r_out_vld;
    assign o_value     = r_value;

endmodule

### hdl/string_to_int_any_base.sv
// top level: string to signed 32-bit integer in a configurable base
// output: the value is loaded into the result register when the terminator leaves the input register
// throughput: one character per cycle; a terminator waits only while the
//   previous value is still held in the result register
// reset: synchronous active low; clears the parse state and loads the
//   decimal alphabet "0123456789" with base 10
module string_to_int_any_base #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    s2i_char_if.sink          i_char,
    s2i_value_if.source       o_value,
    s2i_cfg_if.sink           i_cfg
);
    import s2i_pkg::*;

    t_alpha              w_alpha;
    logic [VALUE_W-1:0]  w_value;

    assign i_cfg.ready = 1'b1;

    s2i_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_alpha (w_alpha)
    );

    s2i_conv #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alpha     (w_alpha),
        .i_in_valid  (i_char.valid),
        .o_in_ready  (i_char.ready),
        .i_char      (i_char.char_code),
        .o_out_valid (o_value.valid),
        .i_out_ready (o_value.ready),
        .o_value     (w_value)
    );

    assign o_value.value = signed'(w_value);

endmodule
